// ===== hdl/rkc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_pkg: shared types and constants of the 3x3 RGB convolution unit
// Beat structs, configuration register indexes, arithmetic widths and the
// stage load enables passed to the per-channel datapath.
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int unsigned PIX_W    = 32;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned CFG_W    = 48;
  localparam int unsigned TAPS     = 9;
  localparam int unsigned PROD_W   = 25;
  localparam int unsigned RSUM_W   = 27;
  localparam int unsigned SUM_W    = 29;
  localparam int unsigned CH_MAX   = 255;
  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 16;

  localparam logic [CFG_W-1:0]    COEF_TOP_RST    = 48'h0;
  localparam logic [CFG_W-1:0]    COEF_MIDDLE_RST = 48'h0000_0100_0000;
  localparam logic [CFG_W-1:0]    COEF_BOTTOM_RST = 48'h0;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST       = 12'd2048;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST      = 16'd1080;

  typedef enum logic [2:0] {
    REG_COEF_TOP    = 3'd0,
    REG_COEF_MIDDLE = 3'd1,
    REG_COEF_BOTTOM = 3'd2,
    REG_WIDTH       = 3'd3,
    REG_HEIGHT      = 3'd4
  } rkc_reg_e;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } rkc_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } rkc_out_t;

  typedef struct packed {
    logic s2_ld;
    logic s3_ld;
    logic out_ld;
  } rkc_stage_en_t;

  typedef logic [TAPS-1:0][COEF_W-1:0]   coef_arr_t;
  typedef logic [TAPS-1:0][SAMPLE_W-1:0] sample_arr_t;
  typedef logic [TAPS-1:0][PIX_W-1:0]    window_t;

endpackage

// ===== hdl/rgb_kernel_convolution_3x3_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_3x3_unit: 3x3 RGB convolution on a raster stream
// Applies a signed Q8.8 kernel to red, green and blue; alpha passes through
// from the centre pixel; border pixels give zero colour.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock and sustains one pixel per clock unless
// the output stalls. Each beat reads both row stores at its column at accept
// and writes them back as it leaves stage one; a back-to-back beat at the
// same column (image width 1) takes the written values from a forwarding
// register. The result for a pixel is caused by the beat width+1 raster
// positions later, so a frame's tail is drained with flush beats. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_3x3_unit #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rkc_pkg::rkc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rkc_pkg::rkc_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [rkc_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned IW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW   = $clog2(MAX_WIDTH + 2);
  localparam int unsigned CMPW = (WW > rkc_pkg::WIDTH_W) ? WW : rkc_pkg::WIDTH_W;
  localparam int unsigned HW   = rkc_pkg::HEIGHT_W;

  logic [rkc_pkg::CFG_W-1:0]    coef_top_q, coef_mid_q, coef_bot_q;
  logic [rkc_pkg::WIDTH_W-1:0]  width_q;
  logic [HW-1:0]                height_q;

  logic [IW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [PW-1:0] pend_q, pend_d;

  logic [WW-1:0]   w_c, cc, col_inc;
  logic [HW-1:0]   h_c, cr;
  logic [HW:0]     row_inc;
  logic [HW+1:0]   cr_t;
  logic [PW-1:0]   pend_inc, pend_nxt;
  logic            is_flush, drop, in_acc, ld1, emit, interior, last;
  logic [rkc_pkg::PIX_W-1:0] px;

  logic                      s1_v_q, s1_emit_q, s1_int_q, s1_last_q, fwd_q;
  logic [IW-1:0]             s1_idx_q;
  logic [rkc_pkg::PIX_W-1:0] s1_px_q, fwd_old_q, fwd_new_q;
  logic [rkc_pkg::PIX_W-1:0] old_rd, new_rd, old_eff, new_eff;
  logic                      s1_adv, fwd_d;

  rkc_pkg::window_t win_q, win_d;

  logic       s2_v_q, s2_int_q, s2_last_q, s3_v_q, s3_int_q, s3_last_q;
  logic       out_v_q, out_int_q, out_last_q;
  logic [7:0] s2_alpha_q, s3_alpha_q, out_alpha_q;
  logic       s2_adv, s3_adv, s2_free;

  rkc_pkg::rkc_stage_en_t en;
  rkc_pkg::coef_arr_t     coef_c;
  logic [2:0][rkc_pkg::CFG_W-1:0] coef_rows;
  logic [2:0][7:0]        ch_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= rkc_pkg::COEF_TOP_RST;
      coef_mid_q <= rkc_pkg::COEF_MIDDLE_RST;
      coef_bot_q <= rkc_pkg::COEF_BOTTOM_RST;
      width_q    <= rkc_pkg::WIDTH_RST;
      height_q   <= rkc_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rkc_pkg::REG_COEF_TOP:    coef_top_q <= cfg_data_i;
        rkc_pkg::REG_COEF_MIDDLE: coef_mid_q <= cfg_data_i;
        rkc_pkg::REG_COEF_BOTTOM: coef_bot_q <= cfg_data_i;
        rkc_pkg::REG_WIDTH:       width_q    <= cfg_data_i[rkc_pkg::WIDTH_W-1:0];
        rkc_pkg::REG_HEIGHT:      height_q   <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // Raster position, pending count and per-beat control, all at accept.
  always_comb begin
    if (width_q == '0) begin
      w_c = WW'(1);
    end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(width_q);
    end
    h_c = (height_q == '0) ? HW'(1) : height_q;

    is_flush = in_data_i.action;
    drop     = is_flush && (pend_q == '0);
    in_acc   = in_valid_i && in_ready_o;
    ld1      = in_acc && !drop;
    px       = is_flush ? '0 : {in_data_i.in_alpha, in_data_i.in_blue,
                                in_data_i.in_green, in_data_i.in_red};

    col_inc = WW'(col_q) + WW'(1);
    row_inc = (HW+1)'(row_q) + (HW+1)'(1);
    cc      = (col_q == '0) ? (w_c - WW'(1)) : (WW'(col_q) - WW'(1));
    cr_t    = (HW+2)'(row_q) - (HW+2)'(1) - (HW+2)'(col_q == '0);
    if (cr_t[HW+1]) begin
      cr = (h_c == HW'(1)) ? '0 : HW'(cr_t + (HW+2)'(h_c));
    end else begin
      cr = cr_t[HW-1:0];
    end

    pend_inc = is_flush ? pend_q : (pend_q + PW'(1));
    emit     = is_flush || (pend_inc > PW'(w_c));
    pend_nxt = emit ? (pend_inc - PW'(1)) : pend_inc;

    interior = (cc != '0) && ((cc + WW'(1)) < w_c) && (cr != '0)
               && (((HW+1)'(cr) + (HW+1)'(1)) < (HW+1)'(h_c));
    last     = (cr == (h_c - HW'(1))) && (cc == (w_c - WW'(1)));

    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    if (ld1) begin
      pend_d = pend_nxt;
      if (col_inc >= w_c) begin
        col_d = '0;
        row_d = (row_inc >= (HW+1)'(h_c)) ? '0 : row_inc[HW-1:0];
      end else begin
        col_d = col_inc[IW-1:0];
      end
      if (emit && last && (pend_nxt == '0)) begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  // Row stores: read at accept, write back when the beat leaves stage one.
  rkc_ram #(
    .WIDTH (rkc_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_older (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q),
    .wdata_i (new_eff),
    .re_i    (ld1),
    .raddr_i (col_q),
    .rdata_o (old_rd)
  );

  rkc_ram #(
    .WIDTH (rkc_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_newer (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q),
    .wdata_i (s1_px_q),
    .re_i    (ld1),
    .raddr_i (col_q),
    .rdata_o (new_rd)
  );

  assign old_eff    = fwd_q ? fwd_old_q : old_rd;
  assign new_eff    = fwd_q ? fwd_new_q : new_rd;
  assign s2_free    = !s2_v_q || s2_adv;
  assign s1_adv     = s1_v_q && (!s1_emit_q || s2_free);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign fwd_d      = s1_adv && (s1_idx_q == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (ld1) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      s1_idx_q  <= col_q;
      s1_px_q   <= px;
      s1_emit_q <= emit;
      s1_int_q  <= interior;
      s1_last_q <= last;
      fwd_q     <= fwd_d;
    end
    if (s1_adv) begin
      fwd_old_q <= new_eff;
      fwd_new_q <= s1_px_q;
    end
  end

  // Window shift.
  always_comb begin
    win_d = win_q;
    for (int r = 0; r < 3; r++) begin
      win_d[3*r]   = win_q[3*r+1];
      win_d[3*r+1] = win_q[3*r+2];
    end
    win_d[2] = old_eff;
    win_d[5] = new_eff;
    win_d[8] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  // Arithmetic pipeline control.
  assign s3_adv = s3_v_q && (!out_v_q || out_ready_i);
  assign s2_adv = s2_v_q && (!s3_v_q || s3_adv);

  always_comb begin
    en.s2_ld  = s1_adv && s1_emit_q;
    en.s3_ld  = s2_adv;
    en.out_ld = s3_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en.s2_ld) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
      if (s3_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s2_ld) begin
      s2_int_q   <= s1_int_q;
      s2_last_q  <= s1_last_q;
      s2_alpha_q <= win_d[4][31:24];
    end
    if (en.s3_ld) begin
      s3_int_q   <= s2_int_q;
      s3_last_q  <= s2_last_q;
      s3_alpha_q <= s2_alpha_q;
    end
    if (en.out_ld) begin
      out_int_q   <= s3_int_q;
      out_last_q  <= s3_last_q;
      out_alpha_q <= s3_alpha_q;
    end
  end

  assign coef_rows[0] = coef_top_q;
  assign coef_rows[1] = coef_mid_q;
  assign coef_rows[2] = coef_bot_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef_c[3*r+c] = coef_rows[r][(rkc_pkg::CFG_W-1-16*c) -: rkc_pkg::COEF_W];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    rkc_pkg::sample_arr_t samples;

    always_comb begin
      for (int k = 0; k < int'(rkc_pkg::TAPS); k++) begin
        samples[k] = win_d[k][8*ch +: 8];
      end
    end

    rkc_chan u_chan (
      .clk_i    (clk_i),
      .en_i     (en),
      .coef_i   (coef_c),
      .sample_i (samples),
      .ch_o     (ch_res[ch])
    );
  end

  assign out_valid_o          = out_v_q;
  assign out_data_o.out_red   = out_int_q ? ch_res[0] : 8'd0;
  assign out_data_o.out_green = out_int_q ? ch_res[1] : 8'd0;
  assign out_data_o.out_blue  = out_int_q ? ch_res[2] : 8'd0;
  assign out_data_o.out_alpha = out_alpha_q;
  assign out_data_o.frame_end = out_last_q;

  a_pend_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    PW'(pend_q) <= PW'(MAX_WIDTH))
    else $error("pending count above the maximum width");

  a_drop_keeps_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && drop) |=> ($stable(col_q) && $stable(row_q) && $stable(pend_q)))
    else $error("dropped flush beat moved the raster position");

  a_last_is_border : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_last_q) |-> !out_int_q)
    else $error("frame end beat marked as interior");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en.s2_ld |-> (!s2_v_q || s2_adv))
    else $error("multiply stage overwritten while holding a beat");

endmodule

// ===== hdl/rkc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port with registered read data. A read of the
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module rkc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rkc_chan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkc_chan: kernel datapath of one colour channel
// Nine signed products, three row sums, then the final sum with clamping to
// 0..255 of its integer part. Each stage loads on its own enable.
// ----------------------------------------------------------------------------
module rkc_chan (
  input  logic                  clk_i,
  input  rkc_pkg::rkc_stage_en_t en_i,
  input  rkc_pkg::coef_arr_t    coef_i,
  input  rkc_pkg::sample_arr_t  sample_i,
  output logic [7:0]            ch_o
);

  logic signed [rkc_pkg::PROD_W-1:0] prod_q [rkc_pkg::TAPS];
  logic signed [rkc_pkg::RSUM_W-1:0] rsum_q [3];
  logic signed [rkc_pkg::SUM_W-1:0]  total;
  logic [7:0]                        res_d;
  logic [7:0]                        res_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2_ld) begin
      for (int k = 0; k < int'(rkc_pkg::TAPS); k++) begin
        prod_q[k] <= $signed(coef_i[k]) * $signed({1'b0, sample_i[k]});
      end
    end
    if (en_i.s3_ld) begin
      for (int r = 0; r < 3; r++) begin
        rsum_q[r] <= rkc_pkg::RSUM_W'(prod_q[3*r]) + rkc_pkg::RSUM_W'(prod_q[3*r+1])
                   + rkc_pkg::RSUM_W'(prod_q[3*r+2]);
      end
    end
    if (en_i.out_ld) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    total = rkc_pkg::SUM_W'(rsum_q[0]) + rkc_pkg::SUM_W'(rsum_q[1])
          + rkc_pkg::SUM_W'(rsum_q[2]);
    if (total[rkc_pkg::SUM_W-1]) begin
      res_d = 8'd0;
    end else if (total[rkc_pkg::SUM_W-2:8] > (rkc_pkg::SUM_W-9)'(rkc_pkg::CH_MAX)) begin
      res_d = 8'(rkc_pkg::CH_MAX);
    end else begin
      res_d = total[15:8];
    end
  end

  assign ch_o = res_q;

endmodule
